FILE: design/gnsplit_pkg.sv
`default_nettype none

package gnsplit_pkg;

    localparam int LINE_DEPTH = 512;
    localparam int RAW_DEPTH  = 256;

    // The line counter stops at LINE_DEPTH-1, the frame counter at RAW_DEPTH.
    localparam int LINE_CNT_W = $clog2(LINE_DEPTH);
    localparam int RAW_CNT_W  = $clog2(RAW_DEPTH + 1);
    localparam int FRAME_W    = 9;
    localparam int SCAN_W     = 7;

    localparam logic [LINE_CNT_W-1:0] LINE_MAX = LINE_CNT_W'(LINE_DEPTH - 1);
    localparam logic [RAW_CNT_W-1:0]  RAW_MAX  = RAW_CNT_W'(RAW_DEPTH);
    localparam logic [SCAN_W-1:0]     SCAN_MAX = '1;
    localparam logic [SCAN_W-1:0]     SCAN_LIMIT = SCAN_W'(90);

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] UBX_SYNC1  = 8'hB5;
    localparam logic [7:0] UBX_SYNC2  = 8'h62;

    localparam logic EV_NMEA = 1'b0;
    localparam logic EV_UBX  = 1'b1;

    localparam logic [2:0] PH_SCAN = 3'd0;
    localparam logic [2:0] PH_HI   = 3'd1;
    localparam logic [2:0] PH_LO   = 3'd2;
    localparam logic [2:0] PH_PASS = 3'd3;
    localparam logic [2:0] PH_FAIL = 3'd4;

    // Control from the stream splitter to the sentence checker.
    typedef struct packed {
        logic                  start;
        logic                  feed;
        logic [7:0]            data;
        logic [LINE_CNT_W-1:0] pos;
    } t_chk_ctl;

    typedef struct packed {
        logic pass;
        logic prefix_good;
    } t_chk_stat;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h37 + {4'd0, nib};
        end
        return r;
    endfunction

    // Expected characters at line positions two to four: "NRM".
    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h4E;
            2'd1:    r = 8'h52;
            default: r = 8'h4D;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/gnss_nmea_ubx_stream_splitter.sv
`default_nettype none

// Channel   Dir  tdata (low bit up)                               tuser
// s_axis    in   [7:0] rx_byte                                    [0] rx_error
// m_axis    out  [8:0] frame_length, [9] checksum_ok,             [0] event_kind
//                [10] rmc_prefix, [15:11] zero
//
// One byte per cycle while the result side is not stalled: a byte waits in the
// input register, and the split and check logic runs as it moves on, loading the
// result register. A result is registered as its byte leaves the input register.
// Reset is synchronous and active low; it clears all counters and the checker.
// A stalled result only holds up the input side when the input register is
// also full; bytes flagged rx_error are taken and dropped.

module gnss_nmea_ubx_stream_splitter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire  [0:0]  i_s_axis_tuser,   // [0] rx_error
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [8:0] frame_length, [9] checksum_ok, [10] rmc_prefix
    output logic [0:0]  o_m_axis_tuser    // [0] event_kind
);
    import gnsplit_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic [7:0]            r_last;
    logic [LINE_CNT_W-1:0] r_line_count, n_line_count;
    logic [RAW_CNT_W-1:0]  r_raw_count, n_raw_count;

    logic               r_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [FRAME_W-1:0] r_out_len, n_out_len;
    logic               r_out_ck, n_out_ck;
    logic               r_out_rmc, n_out_rmc;
    logic               event_fire;

    logic in_xfer, advance, proc;
    logic sync_g, sync_u, line_act, is_nl;

    t_chk_ctl  chk_ctl;
    t_chk_stat chk_stat;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign proc            = r_in_valid && advance;

    assign sync_g   = (r_last == CH_DOLLAR) && (r_in_byte == CH_G);
    assign sync_u   = (r_last == UBX_SYNC1) && (r_in_byte == UBX_SYNC2);
    assign line_act = (r_line_count >= LINE_CNT_W'(2));
    assign is_nl    = (r_in_byte == CH_NEWLINE);

    always_comb begin
        n_line_count  = r_line_count;
        n_raw_count   = r_raw_count;
        event_fire    = 1'b0;
        n_out_kind    = EV_NMEA;
        n_out_len     = '0;
        n_out_ck      = 1'b0;
        n_out_rmc     = 1'b0;
        chk_ctl.start = 1'b0;
        chk_ctl.feed  = 1'b0;
        chk_ctl.data  = r_in_byte;
        chk_ctl.pos   = r_line_count;
        if (sync_g || sync_u) begin
            // A new sync closes any UBX frame in progress.
            if (r_raw_count != '0) begin
                event_fire = 1'b1;
                n_out_kind = EV_UBX;
                n_out_len  = FRAME_W'(r_raw_count - RAW_CNT_W'(1));
            end
            if (sync_g) begin
                n_raw_count   = '0;
                n_line_count  = LINE_CNT_W'(2);
                chk_ctl.start = 1'b1;
            end else begin
                n_raw_count = RAW_CNT_W'(2);
            end
        end else if (line_act) begin
            if (is_nl) begin
                event_fire   = 1'b1;
                n_out_kind   = EV_NMEA;
                n_out_len    = FRAME_W'(r_line_count);
                n_out_ck     = chk_stat.pass;
                n_out_rmc    = chk_stat.prefix_good && (r_line_count >= LINE_CNT_W'(5));
                n_line_count = '0;
            end else if (r_line_count < LINE_MAX) begin
                chk_ctl.feed = 1'b1;
                n_line_count = r_line_count + LINE_CNT_W'(1);
            end
        end else if (r_raw_count >= RAW_CNT_W'(2)) begin
            if (r_raw_count < RAW_MAX) begin
                n_raw_count = r_raw_count + RAW_CNT_W'(1);
            end
        end
        if (!proc) begin
            chk_ctl.start = 1'b0;
            chk_ctl.feed  = 1'b0;
            event_fire    = 1'b0;
        end
    end

    gnsplit_nmea_chk u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (chk_ctl),
        .o_stat  (chk_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_last       <= 8'hFF;
            r_line_count <= '0;
            r_raw_count  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= !i_s_axis_tuser[0];
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_last       <= r_in_byte;
                r_line_count <= n_line_count;
                r_raw_count  <= n_raw_count;
            end
            if (event_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (event_fire) begin
            r_out_kind <= n_out_kind;
            r_out_len  <= n_out_len;
            r_out_ck   <= n_out_ck;
            r_out_rmc  <= n_out_rmc;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tuser[0] = r_out_kind;
    assign o_m_axis_tdata    = {5'd0, r_out_rmc, r_out_ck, r_out_len};

    a_line_never_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count != LINE_CNT_W'(1))
        else $error("line counter holds a partial sync");

    a_raw_never_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_raw_count != RAW_CNT_W'(1) && r_raw_count <= RAW_MAX)
        else $error("frame counter out of range");

    a_ubx_flags_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind == EV_UBX) |-> !r_out_ck && !r_out_rmc)
        else $error("UBX result carries NMEA flags");

    a_nmea_sync_starts_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && sync_g |=> r_line_count == LINE_CNT_W'(2) && r_raw_count == '0)
        else $error("NMEA sync did not open a line");

endmodule

`default_nettype wire

FILE: design/gnsplit_nmea_chk.sv
`default_nettype none

module gnsplit_nmea_chk (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  gnsplit_pkg::t_chk_ctl  i_ctl,
    output gnsplit_pkg::t_chk_stat o_stat
);
    import gnsplit_pkg::*;

    logic [7:0]        r_xor, n_xor;
    logic [2:0]        r_phase, n_phase;
    logic [SCAN_W-1:0] r_scan, n_scan;
    logic              r_prefix, n_prefix;
    logic [LINE_CNT_W-1:0] pos_off;

    assign pos_off = i_ctl.pos - LINE_CNT_W'(2);

    always_comb begin
        n_xor    = r_xor;
        n_phase  = r_phase;
        n_scan   = r_scan;
        n_prefix = r_prefix;
        if (i_ctl.start) begin
            n_xor    = CH_G;
            n_phase  = PH_SCAN;
            n_scan   = SCAN_W'(2);
            n_prefix = 1'b1;
        end else if (i_ctl.feed) begin
            if (i_ctl.pos >= LINE_CNT_W'(2) && i_ctl.pos <= LINE_CNT_W'(4)) begin
                if (i_ctl.data != prefix_char(pos_off[1:0])) begin
                    n_prefix = 1'b0;
                end
            end
            case (r_phase)
                PH_SCAN: begin
                    if (r_scan >= SCAN_LIMIT) begin
                        n_phase = PH_FAIL;
                    end else if (i_ctl.data == CH_STAR) begin
                        n_phase = PH_HI;
                    end else begin
                        n_xor = r_xor ^ i_ctl.data;
                    end
                    if (r_scan != SCAN_MAX) begin
                        n_scan = r_scan + SCAN_W'(1);
                    end
                end
                PH_HI: begin
                    n_phase = (i_ctl.data == hex_digit(r_xor[7:4])) ? PH_LO : PH_FAIL;
                end
                PH_LO: begin
                    n_phase = (i_ctl.data == hex_digit(r_xor[3:0])) ? PH_PASS : PH_FAIL;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor    <= '0;
            r_phase  <= PH_SCAN;
            r_scan   <= '0;
            r_prefix <= 1'b1;
        end else begin
            r_xor    <= n_xor;
            r_phase  <= n_phase;
            r_scan   <= n_scan;
            r_prefix <= n_prefix;
        end
    end

    assign o_stat.pass        = (r_phase == PH_PASS);
    assign o_stat.prefix_good = r_prefix;

    // The high-digit wait can only be entered from the scan.
    a_hi_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HI) && !$past(i_ctl.start) |-> $past(r_phase) == PH_SCAN
            || $past(r_phase) == PH_HI)
        else $error("checksum digit phase entered out of order");

    a_start_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> r_xor == CH_G && r_phase == PH_SCAN && r_prefix)
        else $error("sentence start did not initialize the checker");

    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.start && i_ctl.feed))
        else $error("checker start and feed in the same cycle");

endmodule

`default_nettype wire

FILE: sim/gnss_split_monitor.sv
`timescale 1ns / 100ps

// Watches both streams of the splitter. It tracks the line and frame counters
// from the accepted bytes and compares every result transfer with the oldest
// event that the byte stream predicts.
module gnss_split_monitor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,     // [7:0] rx_byte
    input  wire  [0:0]  i_s_tuser,     // [0] rx_error
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [15:0] i_m_tdata,     // [8:0] frame_length, [9] checksum_ok, [10] rmc_prefix
    input  wire  [0:0]  i_m_tuser,     // [0] event_kind
    output logic [31:0] o_fail_count,
    output logic [31:0] o_waiting
);

    import gnsplit_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [FRAME_W-1:0] length;
        logic               sum_ok;
        logic               rmc;
    } t_split_event;

    // Line positions two to four, lowest byte first: "N", "R", "M".
    localparam logic [23:0] NRM_CHARS = {8'h4D, 8'h52, 8'h4E};

    t_split_event          expected_events[$];
    t_split_event          got_ev;
    t_split_event          want_ev;
    logic [7:0]            prev_byte;
    logic [LINE_CNT_W-1:0] line_bytes;
    logic [RAW_CNT_W-1:0]  frame_bytes;
    logic [7:0]            line_xor;
    logic [2:0]            sum_phase;
    logic [SCAN_W-1:0]     scan_pos;
    logic                  nrm_match;
    int                    fail_n = 0;

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        logic [7:0] c;
        if (nib > 4'd9) begin
            c = {4'd0, nib} - 8'd10 + 8'h41;
        end else begin
            c = {4'd0, nib} + 8'h30;
        end
        return c;
    endfunction

    task automatic note_event(input logic kind, input logic [FRAME_W-1:0] len,
                              input logic ok, input logic rmc);
        t_split_event ev;
        ev.kind   = kind;
        ev.length = len;
        ev.sum_ok = ok;
        ev.rmc    = rmc;
        expected_events.push_back(ev);
    endtask

    task automatic track_byte(input logic [7:0] b);
        int idx;
        if (prev_byte == CH_DOLLAR && b == CH_G) begin
            if (frame_bytes != '0) begin
                note_event(EV_UBX, FRAME_W'(frame_bytes - 1'b1), 1'b0, 1'b0);
                frame_bytes = '0;
            end
            line_bytes = LINE_CNT_W'(2);
            line_xor   = CH_G;
            sum_phase  = PH_SCAN;
            scan_pos   = SCAN_W'(2);
            nrm_match  = 1'b1;
        end else if (prev_byte == UBX_SYNC1 && b == UBX_SYNC2) begin
            if (frame_bytes != '0) begin
                note_event(EV_UBX, FRAME_W'(frame_bytes - 1'b1), 1'b0, 1'b0);
            end
            frame_bytes = RAW_CNT_W'(2);
        end else if (line_bytes >= 2) begin
            if (b == CH_NEWLINE) begin
                note_event(EV_NMEA, FRAME_W'(line_bytes), sum_phase == PH_PASS,
                           nrm_match && line_bytes >= 5);
                line_bytes = '0;
            end else if (line_bytes < LINE_MAX) begin
                if (line_bytes <= 4) begin
                    idx = int'(line_bytes) - 2;
                    if (b != NRM_CHARS[idx*8 +: 8]) begin
                        nrm_match = 1'b0;
                    end
                end
                case (sum_phase)
                    PH_SCAN: begin
                        if (scan_pos >= SCAN_LIMIT) begin
                            sum_phase = PH_FAIL;
                        end else if (b == CH_STAR) begin
                            sum_phase = PH_HI;
                        end else begin
                            line_xor ^= b;
                        end
                        if (scan_pos != SCAN_MAX) begin
                            scan_pos++;
                        end
                    end
                    PH_HI: sum_phase = (b == ascii_hex(line_xor[7:4])) ? PH_LO : PH_FAIL;
                    PH_LO: sum_phase = (b == ascii_hex(line_xor[3:0])) ? PH_PASS : PH_FAIL;
                    default: ;
                endcase
                line_bytes++;
            end
        end else if (frame_bytes >= 2) begin
            if (frame_bytes < RAW_MAX) begin
                frame_bytes++;
            end
        end
        prev_byte = b;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_events.delete();
            prev_byte   = 8'hFF;
            line_bytes  = '0;
            frame_bytes = '0;
            line_xor    = '0;
            sum_phase   = PH_SCAN;
            scan_pos    = '0;
            nrm_match   = 1'b1;
        end else begin
            // Predict first, so a result can never be compared ahead of its byte.
            if (i_s_tvalid && i_s_tready && !i_s_tuser[0]) begin
                track_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got_ev.kind   = i_m_tuser[0];
                got_ev.length = i_m_tdata[8:0];
                got_ev.sum_ok = i_m_tdata[9];
                got_ev.rmc    = i_m_tdata[10];
                if (expected_events.size() == 0) begin
                    fail_n++;
                    $display("%0t: unexpected result: kind %0d length %0d checksum_ok %0d rmc %0d",
                             $time, got_ev.kind, got_ev.length, got_ev.sum_ok, got_ev.rmc);
                end else begin
                    want_ev = expected_events.pop_front();
                    if (got_ev.kind !== want_ev.kind || got_ev.length !== want_ev.length ||
                        got_ev.sum_ok !== want_ev.sum_ok || got_ev.rmc !== want_ev.rmc) begin
                        fail_n++;
                        $display("%0t: result mismatch: expected kind %0d length %0d ok %0d rmc %0d",
                                 $time, want_ev.kind, want_ev.length, want_ev.sum_ok, want_ev.rmc);
                        $display("%0t:                  actual kind %0d length %0d ok %0d rmc %0d",
                                 $time, got_ev.kind, got_ev.length, got_ev.sum_ok, got_ev.rmc);
                    end
                end
            end
        end
        o_waiting    <= 32'(expected_events.size());
        o_fail_count <= 32'(fail_n);
    end

endmodule

FILE: sim/gnss_nmea_ubx_stream_splitter_tb.sv
`timescale 1ns / 100ps

module gnss_nmea_ubx_stream_splitter_tb;

    import gnsplit_pkg::*;

    localparam int          ITEM_GOAL     = 1550;
    localparam int          MIN_SENTENCES = 20;
    localparam logic [7:0]  CH_CR         = 8'h0D;
    localparam logic [31:0] RMC_TALKER    = "NRMC";

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic [0:0]  s_tuser  = 1'b0;    // [0] rx_error
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;            // [8:0] frame_length, [9] checksum_ok, [10] rmc_prefix
    wire  [0:0]  m_tuser;            // [0] event_kind
    wire  [31:0] fail_count;
    wire  [31:0] waiting;

    int items_sent = 0;
    bit quiet      = 1'b0;

    gnss_nmea_ubx_stream_splitter i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    gnss_split_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #9_000_000;
        $display("gnss_nmea_ubx_stream_splitter verification failed");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = (lower ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        if (c == CH_DOLLAR || c == CH_STAR) begin
            c = 8'h41;
        end
        return c;
    endfunction

    task automatic send_raw(input logic [7:0] b, input logic err);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= err;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // A received byte, sometimes preceded by a corrupted one that must be ignored.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < 3) begin
            send_raw(8'($urandom), 1'b1);
        end
        send_raw(b, 1'b0);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_byte(s[k]);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
    endtask

    task automatic send_frame(input int payload);
        send_byte(UBX_SYNC1);
        send_byte(UBX_SYNC2);
        repeat (payload) send_byte(8'($urandom));
    endtask

    task automatic send_sentence(input int body_len, input bit rmc, input bit inner_sync);
        logic [7:0] sum;
        logic [7:0] c;
        int         k;
        int         style;
        send_byte(CH_DOLLAR);
        send_byte(CH_G);
        sum = CH_G;
        for (k = 0; k < body_len; k++) begin
            // The second sync byte of a UBX header never joins the line.
            if (inner_sync && k == body_len / 2) begin
                send_byte(UBX_SYNC1);
                send_byte(UBX_SYNC2);
                sum ^= UBX_SYNC1;
            end
            c = (rmc && k < 4) ? RMC_TALKER[31 - 8*k -: 8] : body_char();
            send_byte(c);
            sum ^= c;
        end
        style = $urandom_range(0, 99);
        if (style < 90) begin
            send_byte(CH_STAR);
            if (style < 70) begin
                send_byte(hex_char(sum[7:4], 1'b0));
                send_byte(hex_char(sum[3:0], 1'b0));
            end else if (style < 78) begin
                send_byte(hex_char(sum[7:4], 1'b0));
                send_byte(hex_char(sum[3:0] ^ 4'($urandom_range(1, 15)), 1'b0));
            end else if (style < 84) begin
                send_byte(hex_char(sum[7:4], 1'b1));
                send_byte(hex_char(sum[3:0], 1'b1));
            end else begin
                send_byte(hex_char(sum[7:4], 1'b0));
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            send_byte(CH_CR);
        end
        send_byte(CH_NEWLINE);
    endtask

    // Broken syncs, stray bytes, lone newlines and lines cut off before their newline.
    task automatic send_noise();
        logic [7:0] c;
        int         pick;
        pick = $urandom_range(0, 4);
        if (pick == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (pick == 1) begin
            c = body_char();
            send_byte(CH_DOLLAR);
            send_byte(c == CH_G ? 8'h48 : c);
        end else if (pick == 2) begin
            c = 8'($urandom);
            send_byte(UBX_SYNC1);
            send_byte(c == UBX_SYNC2 ? 8'h63 : c);
        end else if (pick == 3) begin
            send_byte(CH_DOLLAR);
            send_byte(CH_G);
            repeat ($urandom_range(1, 10)) send_byte(body_char());
        end else begin
            send_byte(CH_NEWLINE);
        end
    endtask

    initial begin : ready_driver
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(60, 150)) @(posedge clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int r;
        int len;
        int sentences;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // A newline with no open line, the byte extremes, an ignored error byte and a short UBX frame.
        send_byte(CH_NEWLINE);
        send_byte(8'h00);
        send_raw(8'hFF, 1'b1);
        send_byte(8'hFF);
        send_frame(2);
        // An error byte between the dollar sign and the G must not break the sync.
        send_byte(CH_DOLLAR);
        send_raw(CH_NEWLINE, 1'b1);
        send_text("G*47\n");
        send_text("$GNRM\n");
        // UBX sync inside a short line.
        send_text("$G");
        send_byte(UBX_SYNC1);
        send_byte(UBX_SYNC2);
        send_byte(CH_NEWLINE);
        drain_results();

        items_sent = 0;
        sentences  = 0;
        while (items_sent < ITEM_GOAL || sentences < MIN_SENTENCES) begin
            r = $urandom_range(0, 99);
            if (sentences == 6) begin
                send_sentence(530, 1'b1, 1'b0);
            end else if (sentences == 13) begin
                send_frame(270);
            end else if (r < 50) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    len = $urandom_range(0, 6);
                end else if (r < 65) begin
                    len = $urandom_range(7, 70);
                end else if (r < 92) begin
                    len = $urandom_range(82, 92);
                end else begin
                    len = $urandom_range(93, 130);
                end
                send_sentence(len, $urandom_range(0, 2) == 0, $urandom_range(0, 19) == 0);
            end else if (r < 75) begin
                send_frame($urandom_range(0, 24));
            end else begin
                send_noise();
            end
            if (sentences % 30 == 15) begin
                drain_results();
            end
            if ($urandom_range(0, 9) == 0) begin
                quiet = ~quiet;
            end
            sentences++;
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("gnss_nmea_ubx_stream_splitter verification clean");
        end else begin
            $display("gnss_nmea_ubx_stream_splitter verification failed");
        end
        $finish;
    end

endmodule
